/* rtl/plb_pkg.sv */
// ----------------------------------------------------------------------------
// plb_pkg: shared types and constants of the price level book
// Level entries, command codes, walk tokens and register indexes.
// ----------------------------------------------------------------------------
package plb_pkg;

	localparam int LEVELS = 32;
	localparam int LVL_W  = $clog2(LEVELS);
	// Cumulative size over all levels of one side.
	localparam int ACC_W  = 32 + LVL_W;

	localparam logic [2:0] REG_UNCROSS_EN = 3'd0;
	localparam logic [2:0] REG_OPEN_MS    = 3'd1;
	localparam logic [2:0] REG_CLOSE_MS   = 3'd2;
	localparam logic [2:0] REG_LOT_SIZE   = 3'd3;
	localparam logic [2:0] REG_THRESHOLD  = 3'd4;

	localparam logic [1:0] ACT_BID_ADD = 2'd0;
	localparam logic [1:0] ACT_BID_DEL = 2'd1;
	localparam logic [1:0] ACT_ASK_ADD = 2'd2;
	localparam logic [1:0] ACT_ASK_DEL = 2'd3;

	typedef enum logic [2:0] {
		CMD_IDLE,
		CMD_ACC,
		CMD_INS,
		CMD_DEL,
		CMD_POP
	} cmd_op_t;

	typedef struct packed {
		logic               v;
		logic signed [31:0] price;
		logic [31:0]        size;
	} level_t;

	typedef struct packed {
		cmd_op_t            op;
		logic signed [31:0] price;
		logic [31:0]        size;
	} cmd_t;

	typedef struct packed {
		logic               found;
		logic signed [31:0] price;
		logic [ACC_W-1:0]   acc;
	} walk_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_FIND,
		ST_APPLY,
		ST_UNCROSS,
		ST_CHECK,
		ST_WALK,
		ST_DIV,
		ST_OUT
	} state_t;

endpackage

/* rtl/plb_cell.sv */
// ----------------------------------------------------------------------------
// plb_cell: one price level of a sorted side chain
// Holds one level, inserts and removes by shifting with its neighbors, and
// carries the cumulative lot search token one cell per cycle.
// ----------------------------------------------------------------------------
module plb_cell (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           high_first,
	input  plb_pkg::cmd_t  cmd,
	input  logic [15:0]    lot,
	input  plb_pkg::level_t prev_lvl,
	input  plb_pkg::level_t next_lvl,
	input  logic           prev_worse,
	input  logic           shift_in,
	input  plb_pkg::walk_t walk_in,
	output plb_pkg::level_t lvl,
	output logic           worse,
	output logic           shift_out,
	output logic           match,
	output logic           err,
	output plb_pkg::walk_t walk_out
);
	import plb_pkg::*;

	level_t           lvl_q;
	walk_t            walk_q;
	walk_t            walk_d;
	logic             kill;
	logic [32:0]      sum;
	logic [ACC_W-1:0] acc;

	assign lvl      = lvl_q;
	assign walk_out = walk_q;
	assign match    = lvl_q.v && (lvl_q.price == cmd.price);
	assign err      = match && (cmd.size > lvl_q.size);
	assign worse    = !lvl_q.v || (high_first ? (lvl_q.price < cmd.price)
	                                          : (lvl_q.price > cmd.price));
	assign kill      = (cmd.op == CMD_DEL) && match && (cmd.size >= lvl_q.size);
	assign shift_out = shift_in || kill;
	assign sum       = {1'b0, lvl_q.size} + {1'b0, cmd.size};
	assign acc       = walk_in.acc + ACC_W'(lvl_q.size);

	always_comb begin
		walk_d = walk_in;
		if (!walk_in.found && lvl_q.v) begin
			walk_d.acc   = acc;
			walk_d.price = lvl_q.price;
			walk_d.found = (acc >= ACC_W'(lot));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lvl_q  <= '0;
			walk_q <= '0;
		end else begin
			walk_q <= walk_d;
			case (cmd.op)
				CMD_ACC: begin
					if (match) lvl_q.size <= sum[32] ? 32'hFFFF_FFFF : sum[31:0];
				end
				CMD_INS: begin
					if (worse) begin
						if (prev_worse) lvl_q <= prev_lvl;
						else lvl_q <= '{v: 1'b1, price: cmd.price, size: cmd.size};
					end
				end
				CMD_DEL, CMD_POP: begin
					if (shift_out) lvl_q <= next_lvl;
					else if (match) lvl_q.size <= lvl_q.size - cmd.size;
				end
				default: ;
			endcase
		end
	end

endmodule

/* rtl/plb_div.sv */
// ----------------------------------------------------------------------------
// plb_div: restoring divider for the lot count
// Divides a cumulative size by the lot size, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module plb_div (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic [plb_pkg::ACC_W-1:0] dividend,
	input  logic [15:0]               divisor,
	output logic                      busy,
	output logic [plb_pkg::ACC_W-1:0] quotient
);
	import plb_pkg::*;

	localparam int CNT_W = $clog2(ACC_W + 1);

	logic             busy_q;
	logic [CNT_W-1:0] cnt_q;
	logic [15:0]      rem_q;
	logic [15:0]      div_q;
	logic [ACC_W-1:0] quo_q;
	logic [16:0]      trial;
	logic             fits;

	assign busy     = busy_q;
	assign quotient = quo_q;
	assign trial    = {rem_q, quo_q[ACC_W-1]};
	assign fits     = (trial >= {1'b0, div_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= CNT_W'(ACC_W);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == CNT_W'(1)) busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			div_q <= divisor;
			quo_q <= dividend;
		end else if (busy_q) begin
			rem_q <= fits ? 16'(trial - {1'b0, div_q}) : trial[15:0];
			quo_q <= {quo_q[ACC_W-2:0], fits};
		end
	end

endmodule

/* rtl/price_level_book_with_uncross.sv */
// ----------------------------------------------------------------------------
// price_level_book_with_uncross: bid/ask price level book with lot quote
// Two sorted chains of level cells, an uncross sequencer and one lot divider per side.
// ----------------------------------------------------------------------------
// Usage: an order transaction (action, price, size, time_ms) enters on the
// in_valid/in_ready channel and produces exactly one quote transaction on
// out_valid/out_ready. The configuration channel (cfg_valid/cfg_ready,
// cfg_index, cfg_data) is always ready and must only be used while the book
// is idle.
// Each side keeps its levels sorted best first in a row of cells, so the best
// level is always the head cell. After acceptance an order passes a find
// state that locates its level and an apply state that applies it. An add
// inside the session with uncrossing armed then drops the opposite best
// level in the uncross state while the book stays crossed, and moves on once
// it is not. A check state follows, then a walk state while the lot search
// token runs down the cell chain, and a divide state that starts the
// bit-serial lot dividers and waits until they are done; an output state
// then loads the output register. in_ready is high only when the sequencer
// is idle; a finished quote sits in the output register and the next
// transaction is accepted while it waits. When the receiver stalls, a
// second quote waits in the last step until the output register frees.
// Reset empties both books, clears the uncrossed flag, sets the last quote to
// ask absent and bid zero, and loads the register defaults.
// ----------------------------------------------------------------------------
module price_level_book_with_uncross (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [2:0]         cfg_index,
	input  logic [26:0]        cfg_data,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [1:0]         action,
	input  logic signed [31:0] price,
	input  logic [31:0]        size,
	input  logic [26:0]        time_ms,
	output logic               out_valid,
	input  logic               out_ready,
	output logic               size_error,
	output logic               table_full,
	output logic               book_crossed,
	output logic               ask_present,
	output logic signed [31:0] ask_price,
	output logic [31:0]        ask_lots,
	output logic               bid_present,
	output logic signed [31:0] bid_price,
	output logic [31:0]        bid_lots,
	output logic               quote_changed
);
	import plb_pkg::*;

	// Configuration registers.
	logic        uncross_en_q;
	logic [26:0] open_ms_q;
	logic [26:0] close_ms_q;
	logic [15:0] lot_q;
	logic [15:0] thr_q;

	// Item being processed.
	state_t             state_q, state_d;
	logic               is_ask_q;
	logic               is_del_q;
	logic signed [31:0] price_q;
	logic [31:0]        size_q;
	logic               in_sess_q;
	logic               hit_q, full_q, err_q;
	logic               size_err_q, tbl_full_q;
	logic               uncrossed_q;
	logic [LVL_W:0]     walk_cnt_q;
	walk_t              ask_w_q, bid_w_q;

	// Last reported quote.
	logic               lq_ask_pres_q;
	logic signed [31:0] lq_ask_price_q;
	logic [31:0]        lq_ask_lots_q;
	logic signed [31:0] lq_bid_price_q;
	logic [31:0]        lq_bid_lots_q;

	// Cell chains.
	cmd_t   bid_cmd, ask_cmd;
	level_t bid_e [LEVELS];
	level_t ask_e [LEVELS];
	walk_t  bid_w [LEVELS];
	walk_t  ask_w [LEVELS];
	logic [LEVELS-1:0] bid_worse, ask_worse, bid_sh, ask_sh;
	logic [LEVELS-1:0] bid_match, ask_match, bid_err, ask_err;

	logic        crossed;
	logic        side_hit, side_full, side_err;
	logic        div_start, ask_busy, bid_busy;
	logic [ACC_W-1:0] ask_quo, bid_quo;
	logic [15:0] lot_eff;
	logic        in_acc;

	// Quote of the current item.
	logic               q_ask_pres;
	logic signed [31:0] q_ask_price;
	logic [31:0]        q_ask_lots;
	logic signed [31:0] q_bid_price;
	logic [31:0]        q_bid_lots;
	logic               q_changed;

	function automatic logic [32:0] abs_diff(logic signed [31:0] a,
	                                         logic signed [31:0] b);
		logic signed [32:0] d;
		d = 33'(a) - 33'(b);
		return d[32] ? 33'(-d) : 33'(d);
	endfunction

	assign cfg_ready = 1'b1;
	assign in_acc    = in_valid && in_ready;
	assign lot_eff   = (lot_q == 16'd0) ? 16'd1 : lot_q;
	assign crossed   = ask_e[0].v && bid_e[0].v && (ask_e[0].price <= bid_e[0].price);

	assign side_hit  = is_ask_q ? |ask_match : |bid_match;
	assign side_err  = is_ask_q ? |ask_err : |bid_err;
	assign side_full = is_ask_q ? ask_e[LEVELS-1].v : bid_e[LEVELS-1].v;

	genvar gi;
	generate
		for (gi = 0; gi < LEVELS; gi++) begin : g_cells
			level_t bid_prev, bid_next, ask_prev, ask_next;
			logic   bid_pw, ask_pw, bid_si, ask_si;
			walk_t  bid_wi, ask_wi;
			if (gi == 0) begin : g_head
				assign bid_prev = '0;
				assign ask_prev = '0;
				assign bid_pw   = 1'b0;
				assign ask_pw   = 1'b0;
				assign bid_si   = (bid_cmd.op == CMD_POP);
				assign ask_si   = (ask_cmd.op == CMD_POP);
				assign bid_wi   = '0;
				assign ask_wi   = '0;
			end else begin : g_body
				assign bid_prev = bid_e[gi-1];
				assign ask_prev = ask_e[gi-1];
				assign bid_pw   = bid_worse[gi-1];
				assign ask_pw   = ask_worse[gi-1];
				assign bid_si   = bid_sh[gi-1];
				assign ask_si   = ask_sh[gi-1];
				assign bid_wi   = bid_w[gi-1];
				assign ask_wi   = ask_w[gi-1];
			end
			if (gi == LEVELS - 1) begin : g_tail
				assign bid_next = '0;
				assign ask_next = '0;
			end else begin : g_mid
				assign bid_next = bid_e[gi+1];
				assign ask_next = ask_e[gi+1];
			end

			plb_cell u_bid (
				.clk(clk), .arst_n(arst_n), .high_first(1'b1), .cmd(bid_cmd),
				.lot(lot_eff), .prev_lvl(bid_prev), .next_lvl(bid_next),
				.prev_worse(bid_pw), .shift_in(bid_si), .walk_in(bid_wi),
				.lvl(bid_e[gi]), .worse(bid_worse[gi]), .shift_out(bid_sh[gi]),
				.match(bid_match[gi]), .err(bid_err[gi]), .walk_out(bid_w[gi])
			);
			plb_cell u_ask (
				.clk(clk), .arst_n(arst_n), .high_first(1'b0), .cmd(ask_cmd),
				.lot(lot_eff), .prev_lvl(ask_prev), .next_lvl(ask_next),
				.prev_worse(ask_pw), .shift_in(ask_si), .walk_in(ask_wi),
				.lvl(ask_e[gi]), .worse(ask_worse[gi]), .shift_out(ask_sh[gi]),
				.match(ask_match[gi]), .err(ask_err[gi]), .walk_out(ask_w[gi])
			);
		end
	endgenerate

	plb_div u_ask_div (
		.clk(clk), .arst_n(arst_n), .start(div_start), .dividend(ask_w_q.acc),
		.divisor(lot_eff), .busy(ask_busy), .quotient(ask_quo)
	);
	plb_div u_bid_div (
		.clk(clk), .arst_n(arst_n), .start(div_start), .dividend(bid_w_q.acc),
		.divisor(lot_eff), .busy(bid_busy), .quotient(bid_quo)
	);

	// Quote assembly and change detection against the last reported quote.
	always_comb begin
		q_ask_pres  = ask_w_q.found && (ask_w_q.price != 32'sd0);
		q_ask_price = q_ask_pres ? ask_w_q.price : 32'sd0;
		q_ask_lots  = !ask_w_q.found ? 32'd0 :
		              (|ask_quo[ACC_W-1:32]) ? 32'hFFFF_FFFF : ask_quo[31:0];
		q_bid_price = bid_w_q.found ? bid_w_q.price : 32'sd0;
		q_bid_lots  = !bid_w_q.found ? 32'd0 :
		              (|bid_quo[ACC_W-1:32]) ? 32'hFFFF_FFFF : bid_quo[31:0];
		q_changed   = (q_ask_pres != lq_ask_pres_q) ||
		              (q_ask_pres && (abs_diff(q_ask_price, lq_ask_price_q) > 33'(thr_q))) ||
		              (q_ask_lots != lq_ask_lots_q) ||
		              (abs_diff(q_bid_price, lq_bid_price_q) > 33'(thr_q)) ||
		              (q_bid_lots != lq_bid_lots_q);
	end

	// Sequencer: next state and the commands driven into the cell chains.
	always_comb begin
		cmd_t item_cmd;
		cmd_t pop_cmd;
		state_d   = state_q;
		in_ready  = (state_q == ST_IDLE);
		div_start = 1'b0;
		item_cmd  = '{op: CMD_IDLE, price: price_q, size: size_q};
		pop_cmd   = '{op: CMD_POP, price: price_q, size: size_q};
		bid_cmd   = '{op: CMD_IDLE, price: price_q, size: size_q};
		ask_cmd   = '{op: CMD_IDLE, price: price_q, size: size_q};
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) state_d = ST_FIND;
			end
			ST_FIND: state_d = ST_APPLY;
			ST_APPLY: begin
				if (is_del_q) item_cmd.op = CMD_DEL;
				else if (size_q != 32'd0 && hit_q) item_cmd.op = CMD_ACC;
				else if (size_q != 32'd0 && !full_q) item_cmd.op = CMD_INS;
				if (is_ask_q) ask_cmd = item_cmd;
				else bid_cmd = item_cmd;
				if (!is_del_q && uncross_en_q && uncrossed_q && in_sess_q)
					state_d = ST_UNCROSS;
				else
					state_d = ST_CHECK;
			end
			ST_UNCROSS: begin
				// Drop the opposite best level while the book stays crossed.
				if (crossed) begin
					if (is_ask_q) bid_cmd = pop_cmd;
					else ask_cmd = pop_cmd;
				end else begin
					state_d = ST_CHECK;
				end
			end
			ST_CHECK: state_d = ST_WALK;
			ST_WALK: begin
				if (walk_cnt_q == (LVL_W+1)'(LEVELS)) state_d = ST_DIV;
			end
			ST_DIV: begin
				if (walk_cnt_q == '0) div_start = 1'b1;
				else if (!ask_busy && !bid_busy) state_d = ST_OUT;
			end
			ST_OUT: begin
				if (!out_valid || out_ready) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else state_q <= state_d;
	end

	// Configuration writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			uncross_en_q <= 1'b0;
			open_ms_q    <= '0;
			close_ms_q   <= 27'd86400000;
			lot_q        <= 16'd100;
			thr_q        <= '0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_UNCROSS_EN: uncross_en_q <= cfg_data[0];
				REG_OPEN_MS:    open_ms_q    <= cfg_data;
				REG_CLOSE_MS:   close_ms_q   <= cfg_data;
				REG_LOT_SIZE:   lot_q        <= cfg_data[15:0];
				REG_THRESHOLD:  thr_q        <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	// Control state of the sequencer and the output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			uncrossed_q    <= 1'b0;
			walk_cnt_q     <= '0;
			out_valid      <= 1'b0;
			lq_ask_pres_q  <= 1'b0;
			lq_ask_price_q <= '0;
			lq_ask_lots_q  <= '0;
			lq_bid_price_q <= '0;
			lq_bid_lots_q  <= '0;
		end else begin
			if (state_q == ST_CHECK) begin
				walk_cnt_q <= '0;
				if (!uncrossed_q && in_sess_q && !crossed) uncrossed_q <= 1'b1;
			end else if (state_q == ST_WALK) begin
				if (walk_cnt_q == (LVL_W+1)'(LEVELS)) walk_cnt_q <= '0;
				else walk_cnt_q <= walk_cnt_q + 1'b1;
			end else if (state_q == ST_DIV) begin
				walk_cnt_q <= (LVL_W+1)'(1);
			end
			// A new quote replaces the one that leaves in the same cycle.
			if (state_q == ST_OUT && (!out_valid || out_ready)) begin
				out_valid <= 1'b1;
				if (q_changed) begin
					lq_ask_pres_q  <= q_ask_pres;
					lq_ask_price_q <= q_ask_price;
					lq_ask_lots_q  <= q_ask_lots;
					lq_bid_price_q <= q_bid_price;
					lq_bid_lots_q  <= q_bid_lots;
				end
			end else if (out_ready) begin
				out_valid <= 1'b0;
			end
		end
	end

	// Item payload and result fields.
	always_ff @(posedge clk) begin
		if (in_acc) begin
			is_ask_q  <= action[1];
			is_del_q  <= action[0];
			price_q   <= price;
			size_q    <= size;
			in_sess_q <= (time_ms >= open_ms_q) && (time_ms < close_ms_q);
		end
		if (state_q == ST_FIND) begin
			hit_q <= side_hit;
			full_q <= side_full;
			err_q <= side_err;
		end
		if (state_q == ST_APPLY) begin
			size_err_q <= is_del_q && (err_q || (!hit_q && size_q != 32'd0));
			tbl_full_q <= !is_del_q && size_q != 32'd0 && !hit_q && full_q;
		end
		if (state_q == ST_WALK && walk_cnt_q == (LVL_W+1)'(LEVELS)) begin
			ask_w_q <= ask_w[LEVELS-1];
			bid_w_q <= bid_w[LEVELS-1];
		end
		if (state_q == ST_OUT && (!out_valid || out_ready)) begin
			size_error    <= size_err_q;
			table_full    <= tbl_full_q;
			book_crossed  <= crossed;
			ask_present   <= q_ask_pres;
			ask_price     <= q_ask_price;
			ask_lots      <= q_ask_lots;
			bid_present   <= bid_w_q.found;
			bid_price     <= q_bid_price;
			bid_lots      <= q_bid_lots;
			quote_changed <= q_changed;
		end
	end

endmodule

/* tb/testbench.sv */
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the price level book with uncross
// Drives order transactions with random gaps and stalls, predicts every
// quote transaction with a scoreboard that models both level tables, and
// compares each quote field by field.
// ----------------------------------------------------------------------------
module testbench;
	import plb_pkg::*;

	localparam int LIMIT_CYCLES = 1500000;
	localparam int SETTLE = 150;

	// One quote as the block reports it.
	typedef struct {
		bit               size_error;
		bit               table_full;
		bit               book_crossed;
		bit               ask_present;
		bit signed [31:0] ask_price;
		bit [31:0]        ask_lots;
		bit               bid_present;
		bit signed [31:0] bid_price;
		bit [31:0]        bid_lots;
		bit               quote_changed;
	} quote_t;

	// The scoreboard keeps its own copy of both books, of the registers and
	// of the last reported quote, and queues the quote each order must give.
	class book_scoreboard;
		bit          lvl_v[2][LEVELS];
		longint      lvl_p[2][LEVELS];
		bit [31:0]   lvl_s[2][LEVELS];
		bit          uncrossed;
		bit          lq_ask_present;
		longint      lq_ask_price;
		bit [31:0]   lq_ask_lots;
		longint      lq_bid_price;
		bit [31:0]   lq_bid_lots;
		bit          uncross_en;
		bit [26:0]   open_ms;
		bit [26:0]   close_ms;
		bit [15:0]   lot;
		bit [15:0]   threshold;
		quote_t      expected_quotes[$];
		int          mismatches;
		int          orders;
		int          quotes;
		int          size_errors;
		int          full_drops;
		int          crossed_seen;

		function new();
			close_ms = 27'd86400000;
			lot = 16'd100;
		endfunction

		function void configure(logic [2:0] idx, logic [26:0] data);
			case (idx)
				REG_UNCROSS_EN: uncross_en = data[0];
				REG_OPEN_MS:    open_ms = data;
				REG_CLOSE_MS:   close_ms = data;
				REG_LOT_SIZE:   lot = data[15:0];
				REG_THRESHOLD:  threshold = data[15:0];
				default: ;
			endcase
		endfunction

		// Next level in walking order beyond prev, or -1 when none is left.
		function int next_level(int sd, bit high_first, bit have_prev, longint prev);
			int best;
			best = -1;
			for (int i = 0; i < LEVELS; i++) begin
				if (!lvl_v[sd][i]) continue;
				if (have_prev && (high_first ? lvl_p[sd][i] >= prev : lvl_p[sd][i] <= prev))
					continue;
				if (best < 0 || (high_first ? lvl_p[sd][i] > lvl_p[sd][best]
						: lvl_p[sd][i] < lvl_p[sd][best]))
					best = i;
			end
			return best;
		endfunction

		function bit crossed();
			int a, b;
			a = next_level(1, 0, 0, 0);
			b = next_level(0, 1, 0, 0);
			return a >= 0 && b >= 0 && lvl_p[1][a] <= lvl_p[0][b];
		endfunction

		function bit in_session(bit [26:0] t);
			return t >= open_ms && t < close_ms;
		endfunction

		// Walks one side best first until the summed size reaches one lot.
		function bit lot_level(int sd, bit high_first, longint unsigned lot_eff,
				output longint px, output bit [31:0] lots);
			longint unsigned acc, q;
			bit have;
			longint prev;
			int i;
			acc = 0;
			have = 0;
			prev = 0;
			px = 0;
			lots = 0;
			for (int k = 0; k < LEVELS; k++) begin
				i = next_level(sd, high_first, have, prev);
				if (i < 0) break;
				acc += lvl_s[sd][i];
				if (acc >= lot_eff) begin
					q = acc / lot_eff;
					lots = q > 64'hFFFFFFFF ? 32'hFFFFFFFF : q[31:0];
					px = lvl_p[sd][i];
					return 1;
				end
				have = 1;
				prev = lvl_p[sd][i];
			end
			return 0;
		endfunction

		function longint unsigned gap_of(longint a, longint b);
			return a >= b ? a - b : b - a;
		endfunction

		// Applies one accepted order and queues the quote it must produce.
		function void note_order(logic [1:0] act, logic signed [31:0] px_in,
				logic [31:0] sz, logic [26:0] t);
			int sd, od, idx, slot, j;
			bit is_del;
			longint px, ap, bp;
			longint unsigned sum, lot_eff;
			bit [31:0] held, al, bl;
			bit af, bf;
			quote_t e;
			sd = act[1];
			od = 1 - sd;
			is_del = act[0];
			px = longint'(px_in);
			e = '{default: 0};
			idx = -1;
			for (int i = 0; i < LEVELS; i++)
				if (idx < 0 && lvl_v[sd][i] && lvl_p[sd][i] == px) idx = i;
			if (!is_del) begin
				if (sz != 0) begin
					if (idx >= 0) begin
						sum = longint'(lvl_s[sd][idx]) + sz;
						lvl_s[sd][idx] = sum > 64'hFFFFFFFF ? 32'hFFFFFFFF : sum[31:0];
					end else begin
						slot = -1;
						for (int i = 0; i < LEVELS; i++)
							if (slot < 0 && !lvl_v[sd][i]) slot = i;
						if (slot < 0) begin
							e.table_full = 1;
						end else begin
							lvl_v[sd][slot] = 1;
							lvl_p[sd][slot] = px;
							lvl_s[sd][slot] = sz;
						end
					end
				end
				// Removes whole opposite best levels while the book stays crossed.
				if (uncross_en && uncrossed && crossed() && in_session(t)) begin
					for (int k = 0; k < LEVELS && crossed(); k++) begin
						j = next_level(od, sd == 1, 0, 0);
						if (j < 0) break;
						lvl_v[od][j] = 0;
					end
				end
			end else begin
				held = idx >= 0 ? lvl_s[sd][idx] : 0;
				e.size_error = sz > held;
				if (idx >= 0) begin
					if (held > sz) lvl_s[sd][idx] = held - sz;
					else lvl_v[sd][idx] = 0;
				end
			end
			if (!uncrossed && in_session(t) && !crossed()) uncrossed = 1;

			lot_eff = lot != 0 ? lot : 1;
			af = lot_level(1, 0, lot_eff, ap, al);
			bf = lot_level(0, 1, lot_eff, bp, bl);
			e.ask_present = af && ap != 0;
			if (!e.ask_present) ap = 0;
			if (!bf) bp = 0;
			e.ask_price = ap;
			e.ask_lots = al;
			e.bid_present = bf;
			e.bid_price = bp;
			e.bid_lots = bl;
			e.book_crossed = crossed();
			e.quote_changed = e.ask_present != lq_ask_present
				|| (e.ask_present && gap_of(ap, lq_ask_price) > threshold)
				|| al != lq_ask_lots
				|| gap_of(bp, lq_bid_price) > threshold
				|| bl != lq_bid_lots;
			if (e.quote_changed) begin
				lq_ask_present = e.ask_present;
				lq_ask_price = ap;
				lq_ask_lots = al;
				lq_bid_price = bp;
				lq_bid_lots = bl;
			end
			orders++;
			size_errors += e.size_error;
			full_drops += e.table_full;
			crossed_seen += e.book_crossed;
			expected_quotes.insert(expected_quotes.size(), e);
		endfunction

		task report(string msg);
			mismatches++;
			$display("MISMATCH quote %0d: %s", quotes, msg);
		endtask

		task check_quote(quote_t got);
			quote_t e;
			quotes++;
			if (expected_quotes.size() == 0) begin
				report("quote with no order outstanding");
				return;
			end
			e = expected_quotes.pop_front();
			if (got.size_error != e.size_error)
				report($sformatf("size_error %0d exp %0d", got.size_error, e.size_error));
			if (got.table_full != e.table_full)
				report($sformatf("table_full %0d exp %0d", got.table_full, e.table_full));
			if (got.book_crossed != e.book_crossed)
				report($sformatf("book_crossed %0d exp %0d", got.book_crossed, e.book_crossed));
			if (got.ask_present != e.ask_present)
				report($sformatf("ask_present %0d exp %0d", got.ask_present, e.ask_present));
			if (got.ask_price != e.ask_price)
				report($sformatf("ask_price %0d exp %0d", got.ask_price, e.ask_price));
			if (got.ask_lots != e.ask_lots)
				report($sformatf("ask_lots %0d exp %0d", got.ask_lots, e.ask_lots));
			if (got.bid_present != e.bid_present)
				report($sformatf("bid_present %0d exp %0d", got.bid_present, e.bid_present));
			if (got.bid_price != e.bid_price)
				report($sformatf("bid_price %0d exp %0d", got.bid_price, e.bid_price));
			if (got.bid_lots != e.bid_lots)
				report($sformatf("bid_lots %0d exp %0d", got.bid_lots, e.bid_lots));
			if (got.quote_changed != e.quote_changed)
				report($sformatf("quote_changed %0d exp %0d", got.quote_changed,
					e.quote_changed));
		endtask
	endclass

	logic               clk;
	logic               arst_n;
	logic               cfg_valid;
	logic               cfg_ready;
	logic [2:0]         cfg_index;
	logic [26:0]        cfg_data;
	logic               in_valid;
	logic               in_ready;
	logic [1:0]         action;
	logic signed [31:0] price;
	logic [31:0]        size;
	logic [26:0]        time_ms;
	logic               out_valid;
	logic               out_ready;
	logic               size_error;
	logic               table_full;
	logic               book_crossed;
	logic               ask_present;
	logic signed [31:0] ask_price;
	logic [31:0]        ask_lots;
	logic               bid_present;
	logic signed [31:0] bid_price;
	logic [31:0]        bid_lots;
	logic               quote_changed;

	book_scoreboard sb;
	quote_t         seen_quote;
	int             cycles;
	// Set by the order process to ask the receiver for one long hold-off.
	bit             hold_request;
	// While set, neither side inserts any idle cycles.
	bit             no_idle;

	price_level_book_with_uncross DUT (.*);

	initial begin
		clk = 0;
		forever #2 clk = ~clk;
	end

	// A cycle counter guards against a hung handshake.
	initial cycles = 0;
	always @(posedge clk) begin
		cycles++;
		if (cycles > LIMIT_CYCLES) begin
			$display("timeout after %0d cycles, %0d quotes outstanding", cycles,
				sb.expected_quotes.size());
			$display("testbench: FAIL");
			$finish;
		end
	end

	// Mostly no gap, often a short one, now and then a long one.
	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (no_idle || r < 55) return 0;
		if (r < 90) return $urandom_range(1, 3);
		return $urandom_range(10, 50);
	endfunction

	// The receiver stalls at random; on request it holds off for a long
	// stretch so that the block fills its output stage and drops in_ready.
	initial begin : receiver
		int stall;
		stall = 0;
		out_ready = 0;
		forever begin
			@(negedge clk);
			if (hold_request) begin
				hold_request = 0;
				stall = 400;
			end
			if (stall > 0) begin
				out_ready = 0;
				stall--;
			end else begin
				out_ready = 1;
				stall = gap_len();
			end
		end
	end

	// Every transaction on the result channel is checked at the edge that
	// takes it.
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			seen_quote.size_error    = size_error;
			seen_quote.table_full    = table_full;
			seen_quote.book_crossed  = book_crossed;
			seen_quote.ask_present   = ask_present;
			seen_quote.ask_price     = ask_price;
			seen_quote.ask_lots      = ask_lots;
			seen_quote.bid_present   = bid_present;
			seen_quote.bid_price     = bid_price;
			seen_quote.bid_lots      = bid_lots;
			seen_quote.quote_changed = quote_changed;
			sb.check_quote(seen_quote);
		end
	end

	// Presents one order and holds it until the block takes it; valid stays
	// high afterwards so that back-to-back transactions are possible.
	task automatic send_order(logic [1:0] act, logic [31:0] px, logic [31:0] sz,
			logic [26:0] t);
		@(negedge clk);
		in_valid = 1;
		action = act;
		price = px;
		size = sz;
		time_ms = t;
		do @(posedge clk); while (!in_ready);
		sb.note_order(act, px, sz, t);
	endtask

	task automatic pause_sender();
		int g;
		g = gap_len();
		if (g > 0) begin
			@(negedge clk);
			in_valid = 0;
			repeat (g - 1) @(negedge clk);
		end
	endtask

	// Waits until every quote is back, then lets the block settle.
	task automatic drain();
		@(negedge clk);
		in_valid = 0;
		while (sb.expected_quotes.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_reg(logic [2:0] idx, logic [26:0] data);
		@(negedge clk);
		cfg_valid = 1;
		cfg_index = idx;
		cfg_data = data;
		do @(posedge clk); while (!cfg_ready);
		sb.configure(idx, data);
		@(negedge clk);
		cfg_valid = 0;
	endtask

	task automatic write_all(bit en, int open_t, int close_t, int lot_v, int thr);
		write_reg(REG_UNCROSS_EN, en);
		write_reg(REG_OPEN_MS, open_t);
		write_reg(REG_CLOSE_MS, close_t);
		write_reg(REG_LOT_SIZE, lot_v);
		write_reg(REG_THRESHOLD, thr);
	endtask

	// Prices crowd a band where bids and asks overlap, so levels repeat,
	// the tables fill and the book crosses; a few land on zero or extremes.
	function automatic logic [31:0] pick_price(bit ask_side);
		int r;
		r = $urandom_range(0, 99);
		if (r < 4) return 0;
		if (r < 8) return $urandom;
		if (r < 10) return r[0] ? 32'h7FFFFFFF : 32'h80000000;
		return (ask_side ? 1020 : 1000) + $urandom_range(0, 59);
	endfunction

	function automatic logic [31:0] pick_size();
		int r, lot_eff;
		r = $urandom_range(0, 99);
		lot_eff = sb.lot != 0 ? sb.lot : 1;
		if (r < 8) return 0;
		if (r < 12) return $urandom;
		if (r < 14) return 32'hFFFFFFFF;
		return $urandom_range(1, 3 * lot_eff);
	endfunction

	function automatic logic [26:0] pick_time();
		int r;
		r = $urandom_range(0, 99);
		if (r < 5) return 0;
		if (r < 10) return 27'd86400000;
		return $urandom_range(0, 86400000);
	endfunction

	initial begin : orders
		int open_t[5]  = '{0, 30000000, 86400000, 0, 0};
		int close_t[5] = '{86400000, 60000000, 0, 134217727, 86400000};
		int lot_v[5]   = '{100, 1, 65535, 0, 250};
		int thr_v[5]   = '{0, 65535, 5, 1, 10};
		bit en_v[5]    = '{1, 1, 0, 1, 1};
		logic [1:0] act;
		sb = new();
		hold_request = 0;
		no_idle = 0;
		cfg_valid = 0;
		cfg_index = REG_UNCROSS_EN;
		cfg_data = 0;
		in_valid = 0;
		action = ACT_BID_ADD;
		price = 0;
		size = 0;
		time_ms = 0;
		arst_n = 0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1;

		// Directed part with the reset register values: partial lots, a
		// clamped delete, deletes at an absent price, saturation, extreme
		// prices, an ask at price zero and a zero-size add.
		send_order(ACT_BID_ADD, 1000, 50, 1000);
		send_order(ACT_BID_ADD, 990, 80, 1000);
		send_order(ACT_ASK_ADD, 1010, 200, 1000);
		send_order(ACT_BID_DEL, 1000, 60, 1000);
		send_order(ACT_BID_DEL, 5555, 10, 1000);
		send_order(ACT_BID_DEL, 5555, 0, 1000);
		send_order(ACT_BID_ADD, 990, 32'hFFFFFFFF, 0);
		send_order(ACT_BID_ADD, 990, 7, 86400000);
		send_order(ACT_ASK_ADD, 32'h7FFFFFFF, 32'hFFFFFFFF, 5000);
		send_order(ACT_ASK_ADD, 32'h80000000, 1, 5000);
		send_order(ACT_ASK_DEL, 32'h80000000, 1, 5000);
		send_order(ACT_ASK_DEL, 1010, 200, 5000);
		send_order(ACT_ASK_ADD, 0, 500, 5000);
		send_order(ACT_ASK_ADD, 1010, 0, 5000);
		send_order(ACT_ASK_DEL, 0, 500, 5000);
		drain();

		// Uncrossing on: a bid through the best ask sweeps it away, and a
		// zero-size add still runs the crossing check.
		write_all(1, 0, 86400000, 100, 0);
		send_order(ACT_ASK_ADD, 1010, 150, 2000);
		send_order(ACT_ASK_ADD, 1020, 150, 2000);
		send_order(ACT_BID_ADD, 1015, 300, 2000);
		send_order(ACT_ASK_ADD, 1000, 0, 2000);
		send_order(ACT_ASK_ADD, 900, 100, 90000000);
		send_order(ACT_BID_ADD, 800, 0, 3000);
		send_order(ACT_BID_DEL, 32'h7FFFFFFF, 32'hFFFFFFFF, 3000);
		drain();

		// Random part in five register settings, extremes included.
		for (int ph = 0; ph < 5; ph++) begin
			write_all(en_v[ph], open_t[ph], close_t[ph], lot_v[ph], thr_v[ph]);
			for (int n = 0; n < 370; n++) begin
				no_idle = (ph == 0 && n < 120);
				if (ph == 1 && n == 100) hold_request = 1;
				if (ph == 2 && n == 150) drain();
				act = $urandom_range(0, 3);
				send_order(act, pick_price(act[1]), pick_size(), pick_time());
				pause_sender();
			end
			drain();
		end

		$display("summary: %0d orders and %0d quotes over six register settings;",
			sb.orders, sb.quotes);
		$display("summary: %0d size errors, %0d full-table drops, %0d crossed quotes",
			sb.size_errors, sb.full_drops, sb.crossed_seen);
		if (sb.mismatches == 0 && sb.expected_quotes.size() == 0) begin
			$display("testbench: PASS");
		end else begin
			$display("testbench: FAIL");
		end
		$finish;
	end

endmodule
